// ===== design/cka_pkg.sv =====
package cka_pkg;

  localparam int MAX_KMER_LEN = 32;
  localparam int KMER_W       = 2 * MAX_KMER_LEN;
  localparam int KLEN_W       = 6;
  localparam int BIDX_W       = $clog2(MAX_KMER_LEN);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(31);
  localparam logic [KLEN_W-1:0] KLEN_MAX   = KLEN_W'(MAX_KMER_LEN);

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef logic [MAX_KMER_LEN-1:0][1:0] kmer_t;

  typedef struct packed {
    logic [7:0] base_char;
    logic       read_end;
  } in_item_t;

  typedef struct packed {
    logic [KMER_W-1:0] canonical_kmer;
    logic [7:0]        arc_mask;
    logic              final_of_read;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

  function automatic logic [1:0] base_code(input logic [7:0] c);
    logic [1:0] code;
    unique case (c)
      8'h43, 8'h63: code = BASE_C;
      8'h47, 8'h67: code = BASE_G;
      8'h54, 8'h74: code = BASE_T;
      default:      code = BASE_A;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] base_onehot(input logic [1:0] b);
    logic [3:0] oh;
    oh = 4'd0;
    oh[b] = 1'b1;
    return oh;
  endfunction

endpackage

// ===== design/cka_core.sv =====
module cka_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  cka_pkg::in_item_t          item,
  input  logic [cka_pkg::KLEN_W-1:0] klen,
  output cka_pkg::push_t             push
);

  cka_pkg::kmer_t                   roll_r, roll_nxt;
  logic [cka_pkg::KLEN_W-1:0]       seen_r, seen_nxt;
  logic                             prev_fwd_r, prev_fwd_nxt;
  cka_pkg::kmer_t                   pend_kmer_r, pend_kmer_nxt;
  logic [7:0]                       pend_arcs_r, pend_arcs_nxt;
  logic                             pend_valid_r, pend_valid_nxt;

  logic [cka_pkg::KLEN_W-1:0]       k;
  logic [cka_pkg::KLEN_W-1:0]       kdiff;
  logic [cka_pkg::BIDX_W-1:0]       ktop;
  cka_pkg::kmer_t                   shifted;
  cka_pkg::kmer_t                   comp;
  cka_pkg::kmer_t                   rev;
  cka_pkg::kmer_t                   twin;
  cka_pkg::kmer_t                   prime;
  logic                             fwd;
  logic                             full;
  logic [1:0]                       cur_last, cur_first, pre_last, pre_first;
  logic [7:0]                       pa, new_arcs;
  logic                             emit_a, emit_b;
  cka_pkg::kmer_t                   after_kmer;
  logic [7:0]                       after_arcs;
  cka_pkg::out_item_t               res_a, res_b;

  always_comb begin
    if (klen == '0) begin
      k = cka_pkg::KLEN_W'(1);
    end else if (klen > cka_pkg::KLEN_MAX) begin
      k = cka_pkg::KLEN_MAX;
    end else begin
      k = klen;
    end
  end

  assign kdiff = cka_pkg::KLEN_MAX - k;
  assign ktop  = cka_pkg::BIDX_W'(k - cka_pkg::KLEN_W'(1));

  assign shifted = {roll_r[cka_pkg::MAX_KMER_LEN-2:0], cka_pkg::base_code(item.base_char)};

  always_comb begin
    for (int j = 0; j < cka_pkg::MAX_KMER_LEN; j++) begin
      roll_nxt[j] = (j < int'(k)) ? shifted[j] : 2'b00;
    end
  end

  always_comb begin
    for (int j = 0; j < cka_pkg::MAX_KMER_LEN; j++) begin
      rev[j] = comp[cka_pkg::MAX_KMER_LEN-1-j];
    end
  end

  assign comp  = ~roll_nxt;
  assign twin  = rev >> {kdiff, 1'b0};
  assign fwd   = roll_nxt >= twin;
  assign prime = fwd ? roll_nxt : twin;

  assign seen_nxt = (seen_r < k) ? seen_r + cka_pkg::KLEN_W'(1) : k;
  assign full     = seen_nxt == k;

  assign cur_last  = prime[0];
  assign cur_first = ~prime[ktop];
  assign pre_last  = pend_kmer_r[0];
  assign pre_first = ~pend_kmer_r[ktop];

  always_comb begin
    pa       = pend_arcs_r;
    new_arcs = 8'd0;
    if (pend_valid_r) begin
      unique case ({prev_fwd_r, fwd})
        2'b11: begin
          pa       = pend_arcs_r | {4'd0, cka_pkg::base_onehot(cur_last)};
          new_arcs = {cka_pkg::base_onehot(pre_first), 4'd0};
        end
        2'b10: begin
          pa       = pend_arcs_r | {4'd0, cka_pkg::base_onehot(cur_first)};
          new_arcs = {4'd0, cka_pkg::base_onehot(pre_first)};
        end
        2'b01: begin
          pa       = pend_arcs_r | {cka_pkg::base_onehot(cur_last), 4'd0};
          new_arcs = {cka_pkg::base_onehot(pre_last), 4'd0};
        end
        default: begin
          pa       = pend_arcs_r | {cka_pkg::base_onehot(cur_first), 4'd0};
          new_arcs = {4'd0, cka_pkg::base_onehot(pre_last)};
        end
      endcase
    end
  end

  assign after_kmer = full ? prime : pend_kmer_r;
  assign after_arcs = full ? new_arcs : pend_arcs_r;
  assign emit_a     = full && pend_valid_r;
  assign emit_b     = item.read_end && (full || pend_valid_r);

  always_comb begin
    res_a.canonical_kmer = pend_kmer_r;
    res_a.arc_mask       = pa;
    res_a.final_of_read  = 1'b0;
    res_a.last           = !emit_b;
    res_b.canonical_kmer = after_kmer;
    res_b.arc_mask       = after_arcs;
    res_b.final_of_read  = 1'b1;
    res_b.last           = 1'b1;
    push.cnt  = go ? {emit_a && emit_b, emit_a ^ emit_b} : 2'd0;
    push.res0 = emit_a ? res_a : res_b;
    push.res1 = res_b;
  end

  always_comb begin
    pend_kmer_nxt  = after_kmer;
    pend_arcs_nxt  = after_arcs;
    pend_valid_nxt = full || pend_valid_r;
    prev_fwd_nxt   = full ? fwd : prev_fwd_r;
    if (item.read_end) begin
      pend_kmer_nxt  = '0;
      pend_arcs_nxt  = 8'd0;
      pend_valid_nxt = 1'b0;
      prev_fwd_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r       <= '0;
      seen_r       <= '0;
      prev_fwd_r   <= 1'b0;
      pend_kmer_r  <= '0;
      pend_arcs_r  <= 8'd0;
      pend_valid_r <= 1'b0;
    end else if (go) begin
      roll_r       <= item.read_end ? '0 : roll_nxt;
      seen_r       <= item.read_end ? '0 : seen_nxt;
      prev_fwd_r   <= prev_fwd_nxt;
      pend_kmer_r  <= pend_kmer_nxt;
      pend_arcs_r  <= pend_arcs_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.read_end |=> !pend_valid_r && seen_r == '0)
    else $error("read state not cleared after read end");
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.res0.last && push.res1.last && push.res1.final_of_read)
    else $error("bad last flags on result pair");
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= cka_pkg::KLEN_MAX)
    else $error("base count beyond maximum k");
`endif

endmodule

// ===== design/cka_queue.sv =====
module cka_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cka_pkg::push_t     push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output cka_pkg::out_item_t out_item
);

  cka_pkg::out_item_t              q_r [cka_pkg::QUEUE_DEPTH];
  logic [cka_pkg::QPTR_W-1:0]      wr_r, rd_r;
  logic [cka_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic [cka_pkg::QPTR_W-1:0]      wr_next1;
  logic                            pop;

  assign room      = cnt_r <= cka_pkg::QCNT_W'(cka_pkg::QUEUE_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_item  = q_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign wr_next1  = wr_r + cka_pkg::QPTR_W'(1);
  assign cnt_nxt   = cnt_r + cka_pkg::QCNT_W'(push.cnt) - cka_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + cka_pkg::QPTR_W'(push.cnt);
      rd_r  <= rd_r + cka_pkg::QPTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_next1] <= push.res1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cka_pkg::QCNT_W'(cka_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("push into queue without room");
`endif

endmodule

// ===== design/canonical_kmer_arc_builder.sv =====
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall  in_item   (base_char, read_end)
// out_     output     out_valid/out_stall out_item (canonical_kmer, arc_mask,
//                                                   final_of_read, last)
// cfg_     input      cfg_valid/cfg_ready cfg_data (kmer_length)
//
// One base per cycle: an item waits in the input register, then its zero
// to two results go to a four-entry result queue. Results leave at one per
// cycle unless stalled, so reads dense in two-result items run at the output
// rate. Input stalls only while the queue has fewer than two free entries.
// Synchronous active-low reset clears read state; kmer_length resets to 31.
module canonical_kmer_arc_builder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cka_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cka_pkg::out_item_t         out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cka_pkg::KLEN_W-1:0] cfg_data
);

  logic                        s1_valid_r;
  cka_pkg::in_item_t           s1_item_r;
  logic [cka_pkg::KLEN_W-1:0]  klen_r;
  logic                        room;
  logic                        go;
  logic                        load;
  cka_pkg::push_t              push;

  assign cfg_ready = 1'b1;
  assign go        = s1_valid_r && room;
  assign in_stall  = s1_valid_r && !room;
  assign load      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      klen_r     <= cka_pkg::KLEN_RESET;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (go) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        klen_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_item;
    end
  end

  cka_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (s1_item_r),
    .klen  (klen_r),
    .push  (push)
  );

  cka_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
